>>> rtl/lzss_byte_decompressor_assert.svh
// assertion macros used by the decompressor rtl
`ifndef LZSS_BYTE_DECOMPRESSOR_ASSERT_SVH
`define LZSS_BYTE_DECOMPRESSOR_ASSERT_SVH
`ifndef SYNTHESIS
`define LZBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LZBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LZBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LZBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/lzbd_pkg.sv
// shared constants and types of the lzss decompressor
package lzbd_pkg;
    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = WIN_AW + 1;
    localparam logic [WIN_AW-1:0] START_POS = WIN_AW'(4078);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);
    localparam int LEN_W = 5;
    localparam logic [LEN_W-1:0] LEN_BIAS = LEN_W'(3);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = FIFO_AW + 1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_item;
endpackage

>>> rtl/lzbd_ram.sv
// simple dual-port ram, one write and one registered read per cycle
module lzbd_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/lzbd_ofifo.sv
// two-entry output queue that decouples the window pipeline from the output stall
module lzbd_ofifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  lzbd_pkg::t_out_item         i_item,
    input  logic                        i_pop,
    output lzbd_pkg::t_out_item         o_item,
    output logic                        o_valid,
    output logic [lzbd_pkg::FIFO_CW-1:0] o_count
);
    import lzbd_pkg::*;

    t_out_item           r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wp;
    logic [FIFO_AW-1:0]  r_rp;
    logic [FIFO_CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + FIFO_CW'(i_push) - FIFO_CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rp];
    assign o_valid = (r_cnt != '0);
    assign o_count = r_cnt;
endmodule

>>> rtl/lzss_byte_decompressor.sv
// lzss decoder: a literal goes straight into the output queue; copy bytes of a pair pass the
// read stage and the write stage, then come out one per cycle while the output is not stalled
// a pair holds the input stalled until its copy is done; a full output queue also stalls it
// one window read and one window write per cycle through a single ram bounds the copy rate
// reset and each stream start empty the window at once by a fill count: no clearing pass
// unwritten window bytes read as zero, write position restarts at 4078
`include "lzss_byte_decompressor_assert.svh"
module lzss_byte_decompressor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_first,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);
    import lzbd_pkg::*;

    typedef enum logic {ST_IDLE, ST_COPY} t_state;
    typedef enum logic [1:0] {PH_FLAG, PH_UNIT, PH_PAIR_HIGH, PH_ENDED} t_phase;

    t_state              r_state,     n_state;
    t_phase              r_phase,     n_phase;
    logic [8:0]          r_flag,      n_flag;
    logic [7:0]          r_pair_low,  n_pair_low;
    logic [WIN_AW-1:0]   r_wpos,      n_wpos;
    logic [FILL_W-1:0]   r_fill,      n_fill;
    logic [WIN_AW-1:0]   r_rd_addr,   n_rd_addr;
    logic [LEN_W-1:0]    r_left,      n_left;
    logic                r_pend,      n_pend;
    logic                r_b_last,    n_b_last;
    logic                r_b_fwd,     n_b_fwd;
    logic                r_b_zero,    n_b_zero;
    logic [7:0]          r_b_fwd_data, n_b_fwd_data;

    logic                in_acc;
    logic                pop;
    logic                push;
    t_out_item           push_item;
    t_out_item           out_item;
    logic [FIFO_CW-1:0]  fifo_cnt;
    logic                we;
    logic [WIN_AW-1:0]   waddr;
    logic [7:0]          wdata;
    logic [7:0]          ram_q;
    logic [7:0]          b_byte;
    logic                start;
    t_phase              ph_eff;
    logic [8:0]          flag_eff;
    logic [8:0]          flag_shr;
    logic [WIN_AW-1:0]   wpos_eff;
    logic [FILL_W-1:0]   fill_eff;
    logic [FIFO_CW:0]    credit;
    logic                issue;
    logic                fwd_hit;
    logic [WIN_AW-1:0]   rd_ofs;

    function automatic logic [FILL_W-1:0] fill_inc(input logic [FILL_W-1:0] f);
        return (f == FILL_FULL) ? f : f + 1'b1;
    endfunction

    assign o_stall = (r_state != ST_IDLE) || (fifo_cnt == FIFO_CW'(FIFO_DEPTH));
    assign in_acc  = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    // byte leaving the read stage: zero if never written, forwarded on a same-entry write
    assign b_byte = r_b_zero ? 8'd0 : (r_b_fwd ? r_b_fwd_data : ram_q);

    // occupied output slots counting the byte already in flight
    assign credit = {1'b0, fifo_cnt} + (FIFO_CW+1)'(r_pend) - (FIFO_CW+1)'(pop);
    assign issue  = (r_state == ST_COPY) && (r_left != '0) &&
                    (credit < (FIFO_CW+1)'(FIFO_DEPTH));
    assign fwd_hit = r_pend && (r_rd_addr == r_wpos);
    assign rd_ofs  = r_rd_addr - START_POS;

    assign start    = i_in_first || (r_phase == PH_ENDED);
    assign ph_eff   = start ? PH_FLAG : r_phase;
    assign flag_eff = start ? 9'd0 : r_flag;
    assign flag_shr = {1'b0, flag_eff[8:1]};
    assign wpos_eff = start ? START_POS : r_wpos;
    assign fill_eff = start ? '0 : r_fill;

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_flag       = r_flag;
        n_pair_low   = r_pair_low;
        n_wpos       = r_wpos;
        n_fill       = r_fill;
        n_rd_addr    = r_rd_addr;
        n_left       = r_left;
        n_pend       = 1'b0;
        n_b_last     = r_b_last;
        n_b_fwd      = r_b_fwd;
        n_b_zero     = r_b_zero;
        n_b_fwd_data = r_b_fwd_data;
        we           = 1'b0;
        waddr        = r_wpos;
        wdata        = b_byte;
        push         = 1'b0;
        push_item    = '{data: b_byte, last: r_b_last};

        if (in_acc) begin
            n_wpos = wpos_eff;
            n_fill = fill_eff;
            if (start) begin
                n_pair_low = 8'd0;
            end
            case (ph_eff)
                PH_FLAG: begin
                    n_flag  = {1'b1, i_in_byte};
                    n_phase = PH_UNIT;
                end
                PH_UNIT: begin
                    if (flag_eff[0]) begin
                        we        = 1'b1;
                        waddr     = wpos_eff;
                        wdata     = i_in_byte;
                        push      = 1'b1;
                        push_item = '{data: i_in_byte, last: 1'b1};
                        n_wpos    = wpos_eff + 1'b1;
                        n_fill    = fill_inc(fill_eff);
                        n_flag    = flag_shr;
                        n_phase   = (flag_shr <= 9'd1) ? PH_FLAG : PH_UNIT;
                    end else begin
                        n_pair_low = i_in_byte;
                        n_phase    = PH_PAIR_HIGH;
                    end
                end
                PH_PAIR_HIGH: begin
                    n_rd_addr = {i_in_byte[7:4], r_pair_low};
                    n_left    = {1'b0, i_in_byte[3:0]} + LEN_BIAS;
                    n_state   = ST_COPY;
                    n_flag    = flag_shr;
                    n_phase   = (flag_shr <= 9'd1) ? PH_FLAG : PH_UNIT;
                end
                default: begin
                end
            endcase
            if (i_in_last) begin
                n_phase    = PH_ENDED;
                n_flag     = 9'd0;
                n_pair_low = 8'd0;
            end
        end

        if (issue) begin
            n_rd_addr    = r_rd_addr + 1'b1;
            n_left       = r_left - 1'b1;
            n_pend       = 1'b1;
            n_b_last     = (r_left == LEN_W'(1));
            n_b_fwd      = fwd_hit;
            n_b_fwd_data = b_byte;
            n_b_zero     = !fwd_hit && ({1'b0, rd_ofs} >= r_fill);
        end

        // write stage of the copy
        if (r_pend) begin
            we     = 1'b1;
            push   = 1'b1;
            n_wpos = r_wpos + 1'b1;
            n_fill = fill_inc(r_fill);
        end

        if ((r_state == ST_COPY) && (r_left == '0) && !r_pend) begin
            n_state = ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_FLAG;
            r_flag       <= 9'd0;
            r_pair_low   <= 8'd0;
            r_wpos       <= START_POS;
            r_fill       <= '0;
            r_rd_addr    <= '0;
            r_left       <= '0;
            r_pend       <= 1'b0;
            r_b_last     <= 1'b0;
            r_b_fwd      <= 1'b0;
            r_b_zero     <= 1'b0;
            r_b_fwd_data <= 8'd0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_flag       <= n_flag;
            r_pair_low   <= n_pair_low;
            r_wpos       <= n_wpos;
            r_fill       <= n_fill;
            r_rd_addr    <= n_rd_addr;
            r_left       <= n_left;
            r_pend       <= n_pend;
            r_b_last     <= n_b_last;
            r_b_fwd      <= n_b_fwd;
            r_b_zero     <= n_b_zero;
            r_b_fwd_data <= n_b_fwd_data;
        end
    end

    lzbd_ram #(
        .DEPTH(WINDOW_DEPTH),
        .WIDTH(8)
    ) u_window (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(r_rd_addr),
        .o_rdata(ram_q)
    );

    lzbd_ofifo u_ofifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (push_item),
        .i_pop  (pop),
        .o_item (out_item),
        .o_valid(o_valid),
        .o_count(fifo_cnt)
    );

    assign o_out_byte = out_item.data;
    assign o_out_last = out_item.last;

    `LZBD_ASSERT_IMP(a_queue_no_overflow, i_clk, i_rst_n, push, (fifo_cnt != FIFO_CW'(FIFO_DEPTH)) || pop, "output queue overflow")
    `LZBD_ASSERT_IMP(a_left_only_in_copy, i_clk, i_rst_n, r_left != '0, r_state == ST_COPY, "copy count outside copy state")
    `LZBD_ASSERT_NXT(a_wpos_advances, i_clk, i_rst_n, r_pend, r_wpos == $past(r_wpos) + 1'b1, "write position did not advance on copy byte")
    `LZBD_ASSERT_IMP(a_fill_bounded, i_clk, i_rst_n, 1'b1, r_fill <= FILL_FULL, "fill count beyond window depth")
endmodule

>>> sim/tb_top.sv
// self-checking bench for the lzss byte decompressor: stream generator, byte-level decoder model, checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lzbd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 200;
    localparam int TAIL_CYCLES = 40;

    typedef enum logic [1:0] {DEC_FLAG, DEC_UNIT, DEC_PAIR_HI, DEC_ENDED} t_dec_phase;

    typedef struct {
        logic [7:0] b;
        logic       first;
        logic       last;
    } t_comp_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       i_in_first;
    logic       i_in_last;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    lzss_byte_decompressor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_byte  (i_in_byte),
        .i_in_first (i_in_first),
        .i_in_last  (i_in_last),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder model state
    logic [7:0]  hist_win [WINDOW_DEPTH];
    logic [11:0] hist_wr;
    logic [8:0]  dec_flags;
    t_dec_phase  dec_ph;
    logic [7:0]  dec_pair_lo;

    t_comp_byte  comp_q[$];
    t_out_item   decoded_q[$];
    t_comp_byte  cur_item;

    bit          in_taken = 1'b0;
    bit          calm = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          cycles = 0;
    int          n_pushed = 0;
    int          n_accepted = 0;
    int          n_checked = 0;
    int          n_pairs = 0;
    int          n_streams = 0;
    int          n_mismatch = 0;
    logic [11:0] gen_pos;

    task automatic restart_decoder();
        for (int i = 0; i < WINDOW_DEPTH; i++) hist_win[i] = 8'h00;
        hist_wr = START_POS;
        dec_flags = '0;
        dec_ph = DEC_FLAG;
        dec_pair_lo = 8'h00;
    endtask

    task automatic put_out(input logic [7:0] b, input logic l);
        t_out_item e;
        hist_win[hist_wr] = b;
        hist_wr = hist_wr + 12'd1;
        e.data = b;
        e.last = l;
        decoded_q.push_back(e);
    endtask

    task automatic advance_unit();
        dec_flags = dec_flags >> 1;
        dec_ph = (dec_flags <= 9'd1) ? DEC_FLAG : DEC_UNIT;
    endtask

    task automatic decode_byte(input t_comp_byte it);
        logic [11:0] rd;
        int          cnt;
        if (it.first || dec_ph == DEC_ENDED) restart_decoder();
        case (dec_ph)
            DEC_FLAG: begin
                dec_flags = {1'b1, it.b};
                dec_ph = DEC_UNIT;
            end
            DEC_UNIT: begin
                if (dec_flags[0]) begin
                    put_out(it.b, 1'b1);
                    advance_unit();
                end else begin
                    dec_pair_lo = it.b;
                    dec_ph = DEC_PAIR_HI;
                end
            end
            default: begin
                // copy reads back bytes it has just written when it overlaps itself
                rd = {it.b[7:4], dec_pair_lo};
                cnt = int'(it.b[3:0]) + 3;
                for (int i = 0; i < cnt; i++) begin
                    put_out(hist_win[rd], i == cnt - 1);
                    rd = rd + 12'd1;
                end
                n_pairs++;
                advance_unit();
            end
        endcase
        if (it.last) begin
            dec_ph = DEC_ENDED;
            dec_flags = '0;
            dec_pair_lo = 8'h00;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic f, input logic l);
        t_comp_byte it;
        it.b = b;
        it.first = f;
        it.last = l;
        comp_q.push_back(it);
        n_pushed++;
    endtask

    // well-formed stream; with cut set the final unit is a pair whose first byte ends it
    task automatic make_stream(input int units, input bit with_first, input bit cut);
        logic [7:0]  flags;
        logic [11:0] pos;
        logic [3:0]  len;
        bit          fin;
        flags = 8'h00;
        gen_pos = START_POS;
        n_streams++;
        for (int u = 0; u < units; u++) begin
            fin = (u == units - 1);
            if (u % 8 == 0) begin
                flags = 8'($urandom);
                if (cut && units - 1 - u < 8) flags[(units - 1) % 8] = 1'b0;
                push_byte(flags, with_first && u == 0, 1'b0);
            end
            if (flags[u % 8]) begin
                push_byte(8'($urandom), 1'b0, fin && !cut);
                gen_pos = gen_pos + 12'd1;
            end else begin
                if ($urandom_range(0, 9) < 7)
                    pos = gen_pos - 12'($urandom_range(1, 24));
                else
                    pos = 12'($urandom);
                len = 4'($urandom);
                push_byte(pos[7:0], 1'b0, fin && cut);
                if (!(fin && cut)) begin
                    push_byte({pos[11:8], len}, 1'b0, fin);
                    gen_pos = gen_pos + 12'(len) + 12'd3;
                end
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // driver: presents the next compressed byte, holds it until the transaction completes
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            // stalled, payload held
        end else begin
            in_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (comp_q.size() > 0) begin
                cur_item = comp_q.pop_front();
                i_in_byte <= cur_item.b;
                i_in_first <= cur_item.first;
                i_in_last <= cur_item.last;
                i_valid <= 1'b1;
                gap_left = pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            decode_byte(cur_item);
            n_accepted++;
            in_taken = 1'b1;
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 1) : $urandom_range(4, 29);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (decoded_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected output byte %02h last %0d", o_out_byte, o_out_last);
            end else begin
                e = decoded_q.pop_front();
                n_checked++;
                if (o_out_byte !== e.data || o_out_last !== e.last) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch on output %0d: expected byte %02h last %0d, got byte %02h last %0d",
                                 n_checked, e.data, e.last, o_out_byte, o_out_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles % 256 == 0) calm = ($urandom_range(0, 3) == 0);
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected", cycles, decoded_q.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        int  r;
        bit  after_noise;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in_byte = 8'h00;
        i_in_first = 1'b0;
        i_in_last = 1'b0;
        i_stall = 1'b0;
        after_noise = 1'b0;
        restart_decoder();

        // flags 1111_0011: two literals, two pairs, four literals
        push_byte(8'hF3, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        // copy of 18 from the start position, overlapping its own output
        push_byte(8'hEE, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        // shortest copy from position zero
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h5A, 1'b0, 1'b0);
        push_byte(8'hA5, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        // all-pair flags, stream ends on the first byte of a pair
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h12, 1'b0, 1'b1);
        // start and end on the same byte
        push_byte(8'h37, 1'b1, 1'b1);
        // restart without a first marker, copy wraps past the window end
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'h42, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hF0, 1'b0, 1'b0);
        // forced restart in the middle of a stream
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'h11, 1'b0, 1'b0);
        push_byte(8'h22, 1'b0, 1'b0);
        push_byte(8'h55, 1'b1, 1'b0);
        push_byte(8'h33, 1'b0, 1'b1);
        n_streams = 5;

        r = n_pushed;
        while (n_pushed < r + RANDOM_ITEMS) begin
            case ($urandom_range(0, 99)) inside
                [0:74]: begin
                    make_stream($urandom_range(1, 24), after_noise || $urandom_range(0, 3) == 0, 1'b0);
                    after_noise = 1'b0;
                end
                [75:86]: begin
                    make_stream($urandom_range(1, 10), after_noise || $urandom_range(0, 1) == 1, 1'b1);
                    after_noise = 1'b0;
                end
                default: begin
                    repeat ($urandom_range(1, 6))
                        push_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
                    after_noise = 1'b1;
                end
            endcase
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_pushed) @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("decoded %0d compressed bytes over about %0d streams, %0d pairs copied",
                 n_accepted, n_streams, n_pairs);
        $display("%0d output bytes compared, %0d mismatches, %0d cycles", n_checked, n_mismatch, cycles);
        if (n_mismatch == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
